// ===== hw/rtl/cpt_pkg.sv =====
// Shared types and codes for the connection port table.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

	// Operation codes carried on func
	localparam logic [2:0] FUNC_ADD_V4 = 3'd0;
	localparam logic [2:0] FUNC_ADD_V6 = 3'd1;
	localparam logic [2:0] FUNC_LOOKUP = 3'd2;
	localparam logic [2:0] FUNC_REMOVE = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam int PORT_W = 16;

	// One stored connection, minus its key
	typedef struct packed {
		logic        is_v6;
		logic [31:0] src_ip;
		logic [63:0] dest_hi;
		logic [63:0] dest_lo;
		logic [15:0] orig_port;
		logic [7:0]  proxy;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;     // latch the transaction and compare its key
		logic encode;      // resolve match and free vectors to indexes
		logic exec;        // issue the entry read
		logic write_entry; // store the entry at the hit or free slot
		logic drop_entry;  // free the hit slot
		logic clear_all;   // free every slot
		logic load_out;    // load the result register
		logic show;        // result carries the found entry
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] func;
		logic       hit;
		logic       free_avail;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cpt_dpath.sv =====
// Datapath: key match cells, free slot search, entry memory and result register.
`timescale 1ns / 1ps
`default_nettype none
module cpt_dpath #(
	parameter int ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cpt_pkg::cmd_t     cmd,
	output cpt_pkg::dp_status_t    dp_st,
	input  wire logic [2:0]        func,
	input  wire logic [15:0]       key_port,
	input  wire logic [31:0]       src_ip,
	input  wire logic [63:0]       dest_addr_hi,
	input  wire logic [63:0]       dest_addr_lo,
	input  wire logic [15:0]       orig_port,
	input  wire logic [7:0]        proxy_id,
	output logic                   is_ipv6,
	output logic [31:0]            found_src_ip,
	output logic [63:0]            found_dest_hi,
	output logic [63:0]            found_dest_lo,
	output logic [15:0]            found_dest_port,
	output logic [7:0]             found_proxy
);
	import cpt_pkg::*;

	localparam int IW = $clog2(ENTRIES);

	logic [ENTRIES-1:0]  valid_q;
	logic [PORT_W-1:0]   port_q [ENTRIES];
	entry_t              mem_q [ENTRIES];
	entry_t              rd_q;

	logic [2:0]          func_q;
	logic [PORT_W-1:0]   key_q;
	entry_t              new_q;

	logic [ENTRIES-1:0]  match_q;
	logic [ENTRIES-1:0]  free_q;
	logic                hit_q;
	logic                free_avail_q;
	logic [IW-1:0]       hit_idx_q;
	logic [IW-1:0]       free_idx_q;

	logic [IW-1:0]       hit_idx_d;
	logic [IW-1:0]       free_idx_d;
	logic [IW-1:0]       wr_idx;

	// At most one valid slot holds a given port, so OR the set index bits
	always_comb begin
		hit_idx_d = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_q[i]) begin
				hit_idx_d = hit_idx_d | IW'(i);
			end
		end
	end

	// Lowest free slot wins
	always_comb begin
		free_idx_d = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx_d = IW'(i);
			end
		end
	end

	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;

	assign dp_st = '{func: func_q, hit: hit_q, free_avail: free_avail_q};

	// Transaction capture, key compare and index encode
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q            <= func;
			key_q             <= key_port;
			new_q.is_v6       <= (func == FUNC_ADD_V6);
			new_q.src_ip      <= src_ip;
			new_q.dest_hi     <= (func == FUNC_ADD_V6) ? dest_addr_hi : 64'd0;
			new_q.dest_lo     <= (func == FUNC_ADD_V6) ? dest_addr_lo
				: {32'd0, dest_addr_lo[31:0]};
			new_q.orig_port   <= orig_port;
			new_q.proxy       <= proxy_id;
			for (int i = 0; i < ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (port_q[i] == key_port);
			end
			free_q <= ~valid_q;
		end
		if (cmd.encode) begin
			hit_q        <= |match_q;
			free_avail_q <= |free_q;
			hit_idx_q    <= hit_idx_d;
			free_idx_q   <= free_idx_d;
		end
	end

	// Slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.write_entry) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (cmd.drop_entry) begin
			valid_q[hit_idx_q] <= 1'b0;
		end
	end

	// Key cells and entry memory
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			port_q[wr_idx] <= key_q;
			mem_q[wr_idx]  <= new_q;
		end
		if (cmd.exec) begin
			rd_q <= mem_q[hit_idx_q];
		end
	end

	// Result register: zero unless a lookup found its port
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			is_ipv6         <= cmd.show ? rd_q.is_v6     : 1'b0;
			found_src_ip    <= cmd.show ? rd_q.src_ip    : 32'd0;
			found_dest_hi   <= cmd.show ? rd_q.dest_hi   : 64'd0;
			found_dest_lo   <= cmd.show ? rd_q.dest_lo   : 64'd0;
			found_dest_port <= cmd.show ? rd_q.orig_port : 16'd0;
			found_proxy     <= cmd.show ? rd_q.proxy     : 8'd0;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cpt_ctrl.sv =====
// Controller: sequences each transaction and owns the handshakes and status.
`timescale 1ns / 1ps
`default_nettype none
module cpt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               status,
	input  wire cpt_pkg::dp_status_t dp_st,
	output cpt_pkg::cmd_t            cmd
);
	import cpt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ENC,
		S_EXEC,
		S_DONE
	} state_t;

	state_t     state_q;
	logic       out_valid_q;
	logic [1:0] code_q;
	logic       show_q;
	logic [1:0] status_q;

	logic [1:0] code_d;
	logic       show_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_comb begin
		cmd             = '0;
		code_d          = ST_MISS;
		show_d          = 1'b0;
		cmd.capture     = (state_q == S_IDLE) && in_valid;
		cmd.encode      = (state_q == S_ENC);
		cmd.exec        = (state_q == S_EXEC);
		cmd.load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready);
		cmd.show        = show_q;
		if (state_q == S_EXEC) begin
			unique case (dp_st.func) inside
				FUNC_ADD_V4, FUNC_ADD_V6: begin
					cmd.write_entry = dp_st.hit || dp_st.free_avail;
					code_d = (dp_st.hit || dp_st.free_avail) ? ST_OK : ST_FULL;
				end
				FUNC_LOOKUP: begin
					show_d = dp_st.hit;
					code_d = dp_st.hit ? ST_OK : ST_MISS;
				end
				FUNC_REMOVE: begin
					cmd.drop_entry = dp_st.hit;
					code_d = dp_st.hit ? ST_OK : ST_MISS;
				end
				FUNC_CLEAR: begin
					cmd.clear_all = 1'b1;
					code_d = ST_OK;
				end
				default: begin
					code_d = ST_MISS;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			code_q      <= ST_OK;
			show_q      <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ENC;
					end
				end
				S_ENC: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					code_q  <= code_d;
					show_q  <= show_d;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the result register is free
					if (cmd.load_out) begin
						status_q    <= code_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/connection_port_table.sv =====
// Top level of the connection table keyed by source port.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  request  | in_valid / in_ready  | func key_port src_ip dest_addr_hi/lo
//           |                      | orig_port proxy_id
//  result   | out_valid / out_ready| status is_ipv6 found_src_ip found_dest_hi/lo
//           |                      | found_dest_port found_proxy
//
// Each transaction runs through key compare against every slot at accept,
// match and free-slot encode, entry write or read, then result load.
// The next request is taken once the result is loaded, even while it waits.
// Reset empties the table at once; slot contents are kept only behind valid bits.
// A stalled result holds the controller in its last step until taken.
`timescale 1ns / 1ps
`default_nettype none
module connection_port_table #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [15:0] key_port,
	input  wire logic [31:0] src_ip,
	input  wire logic [63:0] dest_addr_hi,
	input  wire logic [63:0] dest_addr_lo,
	input  wire logic [15:0] orig_port,
	input  wire logic [7:0]  proxy_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             is_ipv6,
	output logic [31:0]      found_src_ip,
	output logic [63:0]      found_dest_hi,
	output logic [63:0]      found_dest_lo,
	output logic [15:0]      found_dest_port,
	output logic [7:0]       found_proxy
);
	import cpt_pkg::*;

	cmd_t       cmd;
	dp_status_t dp_st;

	cpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.dp_st     (dp_st),
		.cmd       (cmd)
	);

	cpt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.dp_st           (dp_st),
		.func            (func),
		.key_port        (key_port),
		.src_ip          (src_ip),
		.dest_addr_hi    (dest_addr_hi),
		.dest_addr_lo    (dest_addr_lo),
		.orig_port       (orig_port),
		.proxy_id        (proxy_id),
		.is_ipv6         (is_ipv6),
		.found_src_ip    (found_src_ip),
		.found_dest_hi   (found_dest_hi),
		.found_dest_lo   (found_dest_lo),
		.found_dest_port (found_dest_port),
		.found_proxy     (found_proxy)
	);

endmodule
`default_nettype wire

// ===== sim/connection_port_table_tb.sv =====
// Self-checking testbench for the source-port connection table.
`timescale 1ns / 1ps
module connection_port_table_tb;
	import cpt_pkg::*;

	localparam int ENTRIES = 64;
	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [1:0] status;
		entry_t     data;
	} conn_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [15:0] key_port;
	logic [31:0] src_ip;
	logic [63:0] dest_addr_hi;
	logic [63:0] dest_addr_lo;
	logic [15:0] orig_port;
	logic [7:0]  proxy_id;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        is_ipv6;
	logic [31:0] found_src_ip;
	logic [63:0] found_dest_hi;
	logic [63:0] found_dest_lo;
	logic [15:0] found_dest_port;
	logic [7:0]  found_proxy;

	// shadow copy of the table
	bit          tbl_valid [ENTRIES];
	logic [15:0] tbl_port  [ENTRIES];
	entry_t      tbl_entry [ENTRIES];

	conn_result_t expected_results [$];
	int mismatches   = 0;
	int tx_gap_max   = 13;
	int rx_stall_max = 13;

	connection_port_table #(.ENTRIES(ENTRIES)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.key_port        (key_port),
		.src_ip          (src_ip),
		.dest_addr_hi    (dest_addr_hi),
		.dest_addr_lo    (dest_addr_lo),
		.orig_port       (orig_port),
		.proxy_id        (proxy_id),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.is_ipv6         (is_ipv6),
		.found_src_ip    (found_src_ip),
		.found_dest_hi   (found_dest_hi),
		.found_dest_lo   (found_dest_lo),
		.found_dest_port (found_dest_port),
		.found_proxy     (found_proxy)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int find_port_slot(input logic [15:0] port);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_port[i] == port)
				return i;
		return -1;
	endfunction

	function automatic int find_free_slot();
		for (int i = 0; i < ENTRIES; i++)
			if (!tbl_valid[i])
				return i;
		return -1;
	endfunction

	// Apply one operation to the shadow table and return the result it should give.
	function automatic conn_result_t predict_conn(input logic [2:0] f, input logic [15:0] port,
			input logic [31:0] sip, input logic [63:0] dhi, input logic [63:0] dlo,
			input logic [15:0] dport, input logic [7:0] pid);
		conn_result_t r;
		int k;
		r = '0;
		case (f)
			FUNC_ADD_V4, FUNC_ADD_V6: begin
				k = find_port_slot(port);
				if (k < 0)
					k = find_free_slot();
				if (k < 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_valid[k]           = 1'b1;
					tbl_port[k]            = port;
					tbl_entry[k].is_v6     = (f == FUNC_ADD_V6);
					tbl_entry[k].src_ip    = sip;
					tbl_entry[k].dest_hi   = (f == FUNC_ADD_V6) ? dhi : 64'd0;
					tbl_entry[k].dest_lo   = (f == FUNC_ADD_V6) ? dlo : {32'd0, dlo[31:0]};
					tbl_entry[k].orig_port = dport;
					tbl_entry[k].proxy     = pid;
					r.status = ST_OK;
				end
			end
			FUNC_LOOKUP: begin
				k = find_port_slot(port);
				if (k < 0) begin
					r.status = ST_MISS;
				end else begin
					r.status = ST_OK;
					r.data   = tbl_entry[k];
				end
			end
			FUNC_REMOVE: begin
				k = find_port_slot(port);
				if (k < 0) begin
					r.status = ST_MISS;
				end else begin
					tbl_valid[k] = 1'b0;
					r.status = ST_OK;
				end
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					tbl_valid[i] = 1'b0;
				r.status = ST_OK;
			end
			default: r.status = ST_MISS;
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Valid stays high across back-to-back transactions; drop it only for a gap.
	task automatic send_op(input logic [2:0] f, input logic [15:0] port, input logic [31:0] sip,
			input logic [63:0] dhi, input logic [63:0] dlo, input logic [15:0] dport,
			input logic [7:0] pid);
		int gap;
		gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		key_port     <= port;
		src_ip       <= sip;
		dest_addr_hi <= dhi;
		dest_addr_lo <= dlo;
		orig_port    <= dport;
		proxy_id     <= pid;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_conn(f, port, sip, dhi, dlo, dport, pid));
	endtask

	task automatic send_random(input logic [2:0] f, input logic [15:0] port);
		logic [7:0] pid;
		pid = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
		send_op(f, port, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
			16'($urandom), pid);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [2:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22)
			return FUNC_ADD_V4;
		else if (r < 44)
			return FUNC_ADD_V6;
		else if (r < 74)
			return FUNC_LOOKUP;
		else if (r < 92)
			return FUNC_REMOVE;
		else if (r < 95)
			return FUNC_CLEAR;
		return 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
	endfunction

	task automatic test_directed_cases();
		send_op(FUNC_LOOKUP, 16'h0000, '0, '0, '0, '0, '0);
		send_op(FUNC_REMOVE, 16'hFFFF, '0, '0, '0, '0, '0);
		// IPv4 add must drop dest_hi and the upper half of dest_lo
		send_op(FUNC_ADD_V4, 16'h0000, '1, '1, '1, '1, '1);
		send_op(FUNC_LOOKUP, 16'h0000, '0, '0, '0, '0, '0);
		send_op(FUNC_ADD_V6, 16'hFFFF, '0, '1, '1, '0, '0);
		send_op(FUNC_LOOKUP, 16'hFFFF, '1, '0, '0, '1, '1);
		// overwrite in place, switching family both ways
		send_op(FUNC_ADD_V6, 16'h0000, 32'h5A5A_A5A5, 64'hA5A5_5A5A_0F0F_F0F0,
			64'h0123_4567_89AB_CDEF, 16'h8001, 8'h80);
		send_op(FUNC_LOOKUP, 16'h0000, '0, '0, '0, '0, '0);
		send_op(FUNC_ADD_V4, 16'hFFFF, 32'h8000_0001, 64'hDEAD_BEEF_0000_0001,
			64'hFEDC_BA98_7654_3210, 16'h7FFE, 8'h01);
		send_op(FUNC_LOOKUP, 16'hFFFF, '0, '0, '0, '0, '0);
		send_op(FUNC_REMOVE, 16'h0000, '1, '1, '1, '1, '1);
		send_op(FUNC_LOOKUP, 16'h0000, '0, '0, '0, '0, '0);
		send_op(FUNC_REMOVE, 16'h0000, '0, '0, '0, '0, '0);
		for (logic [3:0] f = 4'(FUNC_SPARE_FIRST); f <= 4'(FUNC_SPARE_LAST); f++)
			send_op(f[2:0], 16'hFFFF, '1, '1, '1, '1, '1);
		send_op(FUNC_LOOKUP, 16'hFFFF, '0, '0, '0, '0, '0);
		send_op(FUNC_CLEAR, 16'hFFFF, '1, '1, '1, '1, '1);
		send_op(FUNC_LOOKUP, 16'hFFFF, '0, '0, '0, '0, '0);
		send_op(FUNC_CLEAR, 16'h0000, '0, '0, '0, '0, '0);
	endtask

	// Fill every slot, hit the full case, then free one slot and reuse it.
	task automatic test_table_full();
		logic [15:0] base;
		logic [15:0] ports [ENTRIES + 2];
		base = 16'($urandom);
		// odd multiplier keeps the ports distinct
		for (int i = 0; i < ENTRIES + 2; i++)
			ports[i] = base ^ 16'(i * 16'h9E37);
		send_random(FUNC_CLEAR, base);
		for (int i = 0; i < ENTRIES; i++)
			send_random($urandom_range(0, 1) ? FUNC_ADD_V6 : FUNC_ADD_V4, ports[i]);
		send_random(FUNC_ADD_V4, ports[ENTRIES]);
		send_random(FUNC_ADD_V6, ports[ENTRIES + 1]);
		send_random(FUNC_ADD_V6, ports[0]);
		for (int i = 0; i < 4; i++)
			send_random(FUNC_LOOKUP, ports[$urandom_range(0, ENTRIES - 1)]);
		send_random(FUNC_REMOVE, ports[5]);
		send_random(FUNC_ADD_V4, ports[ENTRIES]);
		send_random(FUNC_ADD_V4, ports[ENTRIES + 1]);
		send_random(FUNC_LOOKUP, ports[ENTRIES]);
		send_random(FUNC_LOOKUP, ports[ENTRIES + 1]);
		send_random(FUNC_LOOKUP, ports[0]);
		send_random(FUNC_CLEAR, base);
	endtask

	task automatic test_random_traffic(input int count, input int pool_size, input int max_idle);
		logic [15:0] pool [$];
		logic [15:0] port;
		tx_gap_max   = max_idle;
		rx_stall_max = max_idle;
		for (int i = 0; i < pool_size; i++)
			pool.push_back(16'($urandom));
		pool[0] = 16'h0000;
		pool[pool_size - 1] = 16'hFFFF;
		for (int n = 0; n < count; n++) begin
			// mostly reuse pool ports so lookups and removes hit
			port = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: pool[$urandom_range(0, pool_size - 1)];
			send_random(pick_func(), port);
		end
	endtask

	// result side: random stall per transaction, then compare with the oldest expectation
	initial begin
		conn_result_t want;
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with no transaction pending, status %0d",
						$time, status);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("is_ipv6", 64'(want.data.is_v6), 64'(is_ipv6));
				check_field("found_src_ip", 64'(want.data.src_ip), 64'(found_src_ip));
				check_field("found_dest_hi", want.data.dest_hi, found_dest_hi);
				check_field("found_dest_lo", want.data.dest_lo, found_dest_lo);
				check_field("found_dest_port", 64'(want.data.orig_port),
					64'(found_dest_port));
				check_field("found_proxy", 64'(want.data.proxy), 64'(found_proxy));
			end
		end
	end

	initial begin
		in_valid     <= 1'b0;
		func         <= FUNC_LOOKUP;
		key_port     <= '0;
		src_ip       <= '0;
		dest_addr_hi <= '0;
		dest_addr_lo <= '0;
		orig_port    <= '0;
		proxy_id     <= '0;
		arst_n       <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_full();
		test_random_traffic(110, 6, 13);
		// hold off until every result is back
		wait_drained();
		test_random_traffic(110, 90, 13);
		tx_gap_max   = 0;
		rx_stall_max = 0;
		test_table_full();
		test_random_traffic(80, 30, 0);
		test_random_traffic(100, 20, 13);

		wait_drained();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_dpath.sv
hw/rtl/cpt_ctrl.sv
hw/rtl/connection_port_table.sv
sim/connection_port_table_tb.sv
